@@ src/bzf_pkg.sv @@
// Shared constants and controller/datapath interface types for the Bezier flattener.
`timescale 1ns / 1ps

package bzf_pkg;

  // Default configuration of the block.
  localparam int BZF_MAX_SEGMENTS = 64;
  localparam int BZF_COORD_BITS   = 16;

  // Fixed width of the sample count field.
  localparam int BZF_COUNT_W = 7;

  // Four Bernstein weights per point.
  localparam int BZF_TAPS   = 4;
  localparam int BZF_TAP_W  = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load;      // capture an input item
    logic                 pt_next;   // advance to the next curve point
    logic                 wt_a;      // squares and triples of a and b
    logic                 wt_b;      // the four weights
    logic                 acc_clr;   // clear the accumulators
    logic                 mul_en;    // multiply one weight by one coordinate
    logic [BZF_TAP_W-1:0] tap;       // which weight and control point
    logic                 acc_en;    // add the registered product
    logic                 div_init;  // load the divider
    logic                 div_step;  // one quotient bit
    logic                 res_load;  // load the output register
  } bzf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;   // item yields the single error result
    logic last;  // current point is the final one
  } bzf_status_t;

endpackage

@@ src/bzf_datapath.sv @@
// Datapath: weight generation, multiply-accumulate and restoring divider for both axes.
`timescale 1ns / 1ps

module bzf_datapath import bzf_pkg::*; #(
  parameter int MAX_SEGMENTS = BZF_MAX_SEGMENTS,
  parameter int COORD_BITS   = BZF_COORD_BITS
) (
  input  logic                         clk,
  input  bzf_cmd_t                     cmd,
  output bzf_status_t                  st,
  input  logic                         in_start_valid,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_ctrl1_x,
  input  logic signed [COORD_BITS-1:0] in_ctrl1_y,
  input  logic signed [COORD_BITS-1:0] in_ctrl2_x,
  input  logic signed [COORD_BITS-1:0] in_ctrl2_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic        [BZF_COUNT_W-1:0] in_sample_count,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y,
  output logic                         out_last,
  output logic                         out_error
);

  localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam int W_W   = 3 * SEG_W;            // a weight never exceeds m^3
  localparam int NUM_W = W_W + COORD_BITS;     // signed numerator
  localparam int LANES = 2;                    // x and y

  // Captured item.
  logic signed [COORD_BITS-1:0] p_r [LANES][BZF_TAPS];
  logic        [SEG_W-1:0]      m_r;
  logic        [SEG_W-1:0]      i_r;
  logic                         err_r;

  // Weight pipeline.
  logic [SEG_W-1:0]   a_r, b_r;
  logic [2*SEG_W-1:0] aa_r, bb_r;
  logic [SEG_W+1:0]   a3_r, b3_r;
  logic [W_W-1:0]     w_r [BZF_TAPS];

  // Multiply-accumulate and divider, one lane per axis.
  logic signed [NUM_W-1:0]      prod_r [LANES];
  logic signed [NUM_W-1:0]      acc_r  [LANES];
  logic        [NUM_W-1:0]      rem_r  [LANES];
  logic        [COORD_BITS-1:0] q_r    [LANES];
  logic                         neg_r  [LANES];
  logic        [NUM_W-1:0]      dsh_r;

  // Output register.
  logic signed [COORD_BITS-1:0] res_r [LANES];
  logic                         last_r;
  logic                         error_r;

  // Combinational helpers.
  logic [BZF_COUNT_W-1:0]  nm1;
  logic [SEG_W-1:0]        m_load;
  logic [SEG_W-1:0]        a_cur;
  logic [2*SEG_W-1:0]      a_ext, b_ext;
  logic [W_W-1:0]          aa_ext, bb_ext, a_w, b_w, a3_w, b3_w;
  logic signed [W_W:0]     wsel_s;
  logic signed [NUM_W-1:0] prod [LANES];
  logic [NUM_W-1:0]        den;
  logic [NUM_W-1:0]        diff [LANES];

  // Segment count, saturated at the maximum.
  always_comb begin
    nm1 = in_sample_count - BZF_COUNT_W'(1);
    if (nm1 > BZF_COUNT_W'(MAX_SEGMENTS)) begin
      m_load = SEG_W'(MAX_SEGMENTS);
    end else begin
      m_load = SEG_W'(nm1);
    end
  end

  // Operands for the weight products, widened so that nothing overflows.
  always_comb begin
    a_cur  = m_r - i_r;
    a_ext  = (2*SEG_W)'(a_cur);
    b_ext  = (2*SEG_W)'(i_r);
    aa_ext = W_W'(aa_r);
    bb_ext = W_W'(bb_r);
    a_w    = W_W'(a_r);
    b_w    = W_W'(b_r);
    a3_w   = W_W'(a3_r);
    b3_w   = W_W'(b3_r);
  end

  // Weight times coordinate for both axes, and the divisor m^3 as the sum of weights.
  always_comb begin
    wsel_s = $signed({1'b0, w_r[cmd.tap]});
    for (int l = 0; l < LANES; l++) begin
      prod[l] = wsel_s * p_r[l][cmd.tap];
      diff[l] = rem_r[l] - dsh_r;
    end
    den = NUM_W'(w_r[0]) + NUM_W'(w_r[1]) + NUM_W'(w_r[2]) + NUM_W'(w_r[3]);
  end

  // Item capture and point index.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r[0][0] <= in_start_x;
      p_r[0][1] <= in_ctrl1_x;
      p_r[0][2] <= in_ctrl2_x;
      p_r[0][3] <= in_end_x;
      p_r[1][0] <= in_start_y;
      p_r[1][1] <= in_ctrl1_y;
      p_r[1][2] <= in_ctrl2_y;
      p_r[1][3] <= in_end_y;
      m_r       <= m_load;
      err_r     <= !in_start_valid || (in_sample_count < BZF_COUNT_W'(2));
      i_r       <= SEG_W'(1);
    end else if (cmd.pt_next) begin
      i_r <= i_r + SEG_W'(1);
    end
  end

  // Bernstein weights in two registered steps.
  always_ff @(posedge clk) begin
    if (cmd.wt_a) begin
      a_r  <= a_cur;
      b_r  <= i_r;
      aa_r <= a_ext * a_ext;
      bb_r <= b_ext * b_ext;
      a3_r <= (SEG_W+2)'(a_cur) + (SEG_W+2)'({a_cur, 1'b0});
      b3_r <= (SEG_W+2)'(i_r) + (SEG_W+2)'({i_r, 1'b0});
    end
    if (cmd.wt_b) begin
      w_r[0] <= aa_ext * a_w;
      w_r[1] <= aa_ext * b3_w;
      w_r[2] <= bb_ext * a3_w;
      w_r[3] <= bb_ext * b_w;
    end
  end

  // Multiply-accumulate and restoring division for both axes.
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (cmd.mul_en) begin
        prod_r[l] <= prod[l];
      end
      if (cmd.acc_clr) begin
        acc_r[l] <= '0;
      end else if (cmd.acc_en) begin
        acc_r[l] <= acc_r[l] + prod_r[l];
      end
      if (cmd.div_init) begin
        neg_r[l] <= acc_r[l][NUM_W-1];
        rem_r[l] <= acc_r[l][NUM_W-1] ? NUM_W'(-acc_r[l]) : NUM_W'(acc_r[l]);
        q_r[l]   <= '0;
      end else if (cmd.div_step) begin
        if (rem_r[l] >= dsh_r) begin
          rem_r[l] <= diff[l];
          q_r[l]   <= {q_r[l][COORD_BITS-2:0], 1'b1};
        end else begin
          q_r[l]   <= {q_r[l][COORD_BITS-2:0], 1'b0};
        end
      end
    end
    if (cmd.div_init) begin
      dsh_r <= den << (COORD_BITS - 1);
    end else if (cmd.div_step) begin
      dsh_r <= dsh_r >> 1;
    end
  end

  // Output register: signed quotient, or the error result.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      for (int l = 0; l < LANES; l++) begin
        if (err_r) begin
          res_r[l] <= '0;
        end else if (neg_r[l]) begin
          res_r[l] <= -$signed(q_r[l]);
        end else begin
          res_r[l] <= $signed(q_r[l]);
        end
      end
      last_r  <= err_r || (i_r == m_r);
      error_r <= err_r;
    end
  end

  assign st.err      = err_r;
  assign st.last     = err_r || (i_r == m_r);
  assign out_point_x = res_r[0];
  assign out_point_y = res_r[1];
  assign out_last    = last_r;
  assign out_error   = error_r;

endmodule

@@ src/bzf_ctrl.sv @@
// Controller: sequences weight, accumulate, divide and output steps for each curve point.
`timescale 1ns / 1ps

module bzf_ctrl import bzf_pkg::*; #(
  parameter int COORD_BITS = BZF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  bzf_status_t st,
  output bzf_cmd_t    cmd
);

  localparam int CNT_W = $clog2(COORD_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_WGT_A,
    S_WGT_B,
    S_MAC,
    S_DIV_INIT,
    S_DIV,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.tap       = cnt_r[BZF_TAP_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (st.err) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_WGT_A;
        end
      end
      S_WGT_A: begin
        cmd.wt_a  = 1'b1;
        state_nxt = S_WGT_B;
      end
      S_WGT_B: begin
        cmd.wt_b    = 1'b1;
        cmd.acc_clr = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_MAC;
      end
      S_MAC: begin
        // Products one tap ahead of the accumulation.
        cmd.mul_en = (cnt_r < CNT_W'(BZF_TAPS));
        cmd.acc_en = (cnt_r != '0);
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(BZF_TAPS)) begin
          state_nxt = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(COORD_BITS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Load the result once, on entry from the divider.
        if (!out_valid_r) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end else if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (st.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pt_next = 1'b1;
            state_nxt   = S_WGT_A;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // State, step counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ src/cubic_bezier_flatten.sv @@
// Top level of the cubic Bezier curve flattener.
//
// The input channel takes one curve per item: start point, two control
// points, end point and the sample count n. For m = min(n-1, MAX_SEGMENTS)
// the result channel then carries m curve points at t = i/m, i = 1..m, each
// coordinate the exact weighted sum divided by m^3 and truncated toward
// zero. The final point carries last. An item without a start point or
// with n below two yields one result with error and last set, point zero.
// Both channels use valid/stall; an item moves when valid is high and
// stall is low. The input stalls for the whole time an item is in work.
// Each point passes through the weight steps, the multiply-accumulate,
// the bit-per-cycle restoring divider and the output register before it
// is offered. A stalled receiver holds the current point and the
// controller waits. Reset clears the controller; the block is ready for
// an item in the first cycle after reset.
`timescale 1ns / 1ps

module cubic_bezier_flatten import bzf_pkg::*; #(
  parameter int MAX_SEGMENTS = BZF_MAX_SEGMENTS,
  parameter int COORD_BITS   = BZF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_valid,
  input  logic signed [COORD_BITS-1:0]  in_start_x,
  input  logic signed [COORD_BITS-1:0]  in_start_y,
  input  logic signed [COORD_BITS-1:0]  in_ctrl1_x,
  input  logic signed [COORD_BITS-1:0]  in_ctrl1_y,
  input  logic signed [COORD_BITS-1:0]  in_ctrl2_x,
  input  logic signed [COORD_BITS-1:0]  in_ctrl2_y,
  input  logic signed [COORD_BITS-1:0]  in_end_x,
  input  logic signed [COORD_BITS-1:0]  in_end_y,
  input  logic        [BZF_COUNT_W-1:0] in_sample_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_point_x,
  output logic signed [COORD_BITS-1:0]  out_point_y,
  output logic                          out_last,
  output logic                          out_error
);

  bzf_cmd_t    cmd;
  bzf_status_t st;

  // Sequencer.
  bzf_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Arithmetic.
  bzf_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .st              (st),
    .in_start_valid  (in_start_valid),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_ctrl1_x      (in_ctrl1_x),
    .in_ctrl1_y      (in_ctrl1_y),
    .in_ctrl2_x      (in_ctrl2_x),
    .in_ctrl2_y      (in_ctrl2_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_sample_count (in_sample_count),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_last        (out_last),
    .out_error       (out_error)
  );

endmodule

@@ verif/bzf_curve_checker.sv @@
// Checker for the Bezier flattener: predicts the curve points of each item and compares them.
`timescale 1ns / 1ps

module bzf_curve_checker import bzf_pkg::*; #(
  parameter int MAX_SEGMENTS = BZF_MAX_SEGMENTS,
  parameter int COORD_BITS   = BZF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_start_valid,
  input  logic signed [COORD_BITS-1:0]  in_start_x,
  input  logic signed [COORD_BITS-1:0]  in_start_y,
  input  logic signed [COORD_BITS-1:0]  in_ctrl1_x,
  input  logic signed [COORD_BITS-1:0]  in_ctrl1_y,
  input  logic signed [COORD_BITS-1:0]  in_ctrl2_x,
  input  logic signed [COORD_BITS-1:0]  in_ctrl2_y,
  input  logic signed [COORD_BITS-1:0]  in_end_x,
  input  logic signed [COORD_BITS-1:0]  in_end_y,
  input  logic        [BZF_COUNT_W-1:0] in_sample_count,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [COORD_BITS-1:0]  out_point_x,
  input  logic signed [COORD_BITS-1:0]  out_point_y,
  input  logic                          out_last,
  input  logic                          out_error,
  output int                            mismatches,
  output int                            outstanding,
  output int                            curves_taken,
  output int                            points_taken,
  output int                            error_points
);

  // One expected result item.
  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
    logic                         err;
  } curve_point_t;

  curve_point_t expected_points[$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    curves_taken = 0;
    points_taken = 0;
    error_points = 0;
  end

  // Exact weighted sum of the four control coordinates over seg^3, truncated toward zero.
  function automatic logic signed [COORD_BITS-1:0] curve_coord(
    input longint p1, input longint p2, input longint p3, input longint p4,
    input longint seg, input longint idx);
    longint a;
    longint num;
    longint den;
    a   = seg - idx;
    num = a * a * a * p1 + 3 * a * a * idx * p2 + 3 * a * idx * idx * p3
        + idx * idx * idx * p4;
    den = seg * seg * seg;
    return COORD_BITS'(num / den);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // Queue every point that an accepted item must produce.
  task automatic predict_curve();
    int           seg;
    curve_point_t pt;
    curves_taken++;
    if (!in_start_valid || in_sample_count < 2) begin
      // A missing start point or too few samples gives one error item.
      pt.x    = '0;
      pt.y    = '0;
      pt.last = 1'b1;
      pt.err  = 1'b1;
      expected_points.push_back(pt);
    end else begin
      seg = int'(in_sample_count) - 1;
      if (seg > MAX_SEGMENTS) begin
        seg = MAX_SEGMENTS;
      end
      for (int idx = 1; idx <= seg; idx++) begin
        pt.x    = curve_coord(in_start_x, in_ctrl1_x, in_ctrl2_x, in_end_x, seg, idx);
        pt.y    = curve_coord(in_start_y, in_ctrl1_y, in_ctrl2_y, in_end_y, seg, idx);
        pt.last = (idx == seg);
        pt.err  = 1'b0;
        expected_points.push_back(pt);
      end
    end
  endtask

  // Compare one accepted result item with the oldest expectation.
  task automatic check_point();
    curve_point_t want;
    points_taken++;
    if (out_error) begin
      error_points++;
    end
    if (expected_points.size() == 0) begin
      note_mismatch($sformatf("point %0d arrived with nothing expected (%0d,%0d) last=%0b err=%0b",
                              points_taken, out_point_x, out_point_y, out_last, out_error));
      return;
    end
    want = expected_points.pop_front();
    if (out_point_x !== want.x) begin
      note_mismatch($sformatf("point %0d x: expected %0d, got %0d", points_taken, want.x,
                              out_point_x));
    end
    if (out_point_y !== want.y) begin
      note_mismatch($sformatf("point %0d y: expected %0d, got %0d", points_taken, want.y,
                              out_point_y));
    end
    if (out_last !== want.last) begin
      note_mismatch($sformatf("point %0d last: expected %0b, got %0b", points_taken, want.last,
                              out_last));
    end
    if (out_error !== want.err) begin
      note_mismatch($sformatf("point %0d error: expected %0b, got %0b", points_taken, want.err,
                              out_error));
    end
  endtask

  // Results are checked before new items are predicted so that the two never cross.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_point();
      end
      if (in_valid && !in_stall) begin
        predict_curve();
      end
    end
    outstanding <= expected_points.size();
  end

endmodule

@@ verif/tb_cubic_bezier_flatten.sv @@
// Testbench top for the Bezier flattener: clock, reset, curve stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_cubic_bezier_flatten;
  import bzf_pkg::*;

  localparam int CW             = BZF_COORD_BITS;
  localparam int RANDOM_CURVES  = 280;
  localparam int TAIL_CURVES    = 40;
  localparam int SETTLE_CYCLES  = BZF_COORD_BITS + 30;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_start_valid;
  logic signed [CW-1:0]    in_start_x;
  logic signed [CW-1:0]    in_start_y;
  logic signed [CW-1:0]    in_ctrl1_x;
  logic signed [CW-1:0]    in_ctrl1_y;
  logic signed [CW-1:0]    in_ctrl2_x;
  logic signed [CW-1:0]    in_ctrl2_y;
  logic signed [CW-1:0]    in_end_x;
  logic signed [CW-1:0]    in_end_y;
  logic [BZF_COUNT_W-1:0]  in_sample_count;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [CW-1:0]    out_point_x;
  logic signed [CW-1:0]    out_point_y;
  logic                    out_last;
  logic                    out_error;

  int mismatches;
  int outstanding;
  int curves_taken;
  int points_taken;
  int error_points;
  int quiet_cycles = 0;
  int calm_left    = 0;
  bit quiet_tail   = 1'b0;
  bit gaps_on      = 1'b1;

  always #1 clk = ~clk;

  cubic_bezier_flatten u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_valid  (in_start_valid),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_ctrl1_x      (in_ctrl1_x),
    .in_ctrl1_y      (in_ctrl1_y),
    .in_ctrl2_x      (in_ctrl2_x),
    .in_ctrl2_y      (in_ctrl2_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_sample_count (in_sample_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_last        (out_last),
    .out_error       (out_error)
  );

  bzf_curve_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_valid  (in_start_valid),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_ctrl1_x      (in_ctrl1_x),
    .in_ctrl1_y      (in_ctrl1_y),
    .in_ctrl2_x      (in_ctrl2_x),
    .in_ctrl2_y      (in_ctrl2_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_sample_count (in_sample_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_last        (out_last),
    .out_error       (out_error),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .curves_taken    (curves_taken),
    .points_taken    (points_taken),
    .error_points    (error_points)
  );

  // Offer one curve item and hold it until the block takes it.
  task automatic send_curve(input logic sv,
                            input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                            input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                            input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
                            input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey,
                            input logic [BZF_COUNT_W-1:0] n);
    in_valid        <= 1'b1;
    in_start_valid  <= sv;
    in_start_x      <= sx;
    in_start_y      <= sy;
    in_ctrl1_x      <= ax;
    in_ctrl1_y      <= ay;
    in_ctrl2_x      <= bx;
    in_ctrl2_y      <= by;
    in_end_x        <= ex;
    in_end_y        <= ey;
    in_sample_count <= n;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic rest_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off new items until every expected point has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Coordinates lean toward the extremes and toward small values near zero.
  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return CW'($urandom_range(0, 20)) - CW'(10);
      default: return CW'($urandom);
    endcase
  endfunction

  // Mostly well-formed curves of modest length, some long or saturated, some error items.
  task automatic random_curve();
    int                     roll;
    logic                   sv;
    logic [BZF_COUNT_W-1:0] n;
    roll = $urandom_range(0, 99);
    sv   = 1'b1;
    if (roll < 8) begin
      sv = 1'b0;
      n  = BZF_COUNT_W'($urandom);
    end else if (roll < 14) begin
      n = BZF_COUNT_W'($urandom_range(0, 1));
    end else if (roll < 22) begin
      n = BZF_COUNT_W'($urandom);
    end else begin
      n = BZF_COUNT_W'($urandom_range(2, 17));
    end
    send_curve(sv, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_coord(), pick_coord(), n);
  endtask

  // Receiver stalls come in bursts, with calm stretches in between and none at the end.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left > 0) begin
        calm_left--;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 30) == 0) begin
        calm_left = $urandom_range(20, 150);
      end
    end
  end

  // The watchdog ends the run when no item moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    in_valid        <= 1'b0;
    in_start_valid  <= 1'b0;
    in_start_x      <= '0;
    in_start_y      <= '0;
    in_ctrl1_x      <= '0;
    in_ctrl1_y      <= '0;
    in_ctrl2_x      <= '0;
    in_ctrl2_y      <= '0;
    in_end_x        <= '0;
    in_end_y        <= '0;
    in_sample_count <= '0;
    rst_n           <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Error items: no start point, and sample counts below two.
    send_curve(1'b0, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 16'sd9, 16'sd10, 16'sd11, 16'sd12, 7'd5);
    send_curve(1'b0, '0, '0, '0, '0, '0, '0, '0, '0, 7'd0);
    send_curve(1'b1, 16'sd100, -16'sd100, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 7'd0);
    send_curve(1'b1, 16'sd100, -16'sd100, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 7'd1);

    // A single segment lands exactly on the end point.
    send_curve(1'b1, -16'sd7, 16'sd9, 16'sd1000, -16'sd1000, 16'sd55, 16'sd66, 16'sd321, -16'sd4,
               7'd2);

    // Small negative and positive spans exercise truncation toward zero.
    send_curve(1'b1, '0, '0, '0, '0, -16'sd1, 16'sd1, -16'sd1, 16'sd1, 7'd4);
    send_curve(1'b1, 16'sd1, -16'sd1, -16'sd2, 16'sd2, 16'sd2, -16'sd2, -16'sd1, 16'sd1, 7'd7);

    // Coordinate extremes, all equal and alternating.
    send_curve(1'b1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
               COORD_MIN, COORD_MIN, 7'd3);
    send_curve(1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
               COORD_MAX, COORD_MAX, 7'd4);
    send_curve(1'b1, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
               COORD_MAX, COORD_MIN, 7'd65);

    // Sample counts just below and beyond the segment limit, where the count saturates.
    send_curve(1'b1, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
               COORD_MIN, COORD_MAX, 7'd64);
    send_curve(1'b1, -16'sd1234, 16'sd4321, 16'sd20000, -16'sd20000, -16'sd30000, 16'sd30000,
               16'sd17, -16'sd17, 7'd66);
    send_curve(1'b1, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 7'd127);

    drain_results();

    // Random curves, with sender gaps, occasional draining and a calm tail.
    for (int k = 0; k < RANDOM_CURVES; k++) begin
      if (k % 20 == 0) begin
        gaps_on = ($urandom_range(0, 2) != 0);
      end
      if (k == RANDOM_CURVES - TAIL_CURVES) begin
        quiet_tail = 1'b1;
      end
      if (!quiet_tail && k % 60 == 30) begin
        drain_results();
      end else if (!quiet_tail && gaps_on && $urandom_range(0, 3) == 0) begin
        rest_sender($urandom_range(1, 13));
      end
      random_curve();
    end

    // Let the last points arrive, then watch a while for stray ones.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d curve items sent, %0d points checked, %0d of them error items",
             curves_taken, points_taken, error_points);
    $display("summary: counts from 0 to 127, coordinate extremes, random stalls on both sides");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
